// ===== src/ksm_pkg.sv =====
// Shared types and constants for the key sequence matcher.
`timescale 1ns / 1ps
`default_nettype none

package ksm_pkg;

  localparam int HIST_W      = 32;
  localparam int LETTER_BITS = 5;
  localparam logic [7:0] LETTER_BASE = 8'h61;  // 'a'
  localparam logic [7:0] LETTER_LAST = 8'h80;  // 'a' + 31
  localparam logic [7:0] UPPER_FIRST = 8'h41;  // 'A'
  localparam logic [7:0] UPPER_LAST  = 8'h5A;  // 'Z'
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_RESOLVE,
    S_EMIT
  } ksm_state_t;

  // One pattern table slot as written into a cell.
  typedef struct packed {
    logic [HIST_W-1:0] code;
    logic [HIST_W-1:0] mask;
    logic [3:0]        args;
    logic              valid;
  } ksm_entry_t;

  // Priority data handed from cell to cell along the row.
  typedef struct packed {
    logic       zero_found;
    logic       arg_found;
    logic [3:0] arg_cnt;
  } ksm_chain_t;

  // One result item.
  typedef struct packed {
    logic        consumed;
    logic        fired;
    logic [3:0]  fired_entry;
    logic [3:0]  arg_count;
    logic [63:0] arg_bytes;
  } ksm_res_t;

endpackage

`default_nettype wire

// ===== src/ksm_cell.sv =====
// One pattern slot: stored entry, masked compare and priority hand-off to the next cell.
`timescale 1ns / 1ps
`default_nettype none

module ksm_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  ksm_pkg::ksm_entry_t          wr_entry,
  input  wire                          match_en,
  input  wire [ksm_pkg::HIST_W-1:0]    history,
  input  ksm_pkg::ksm_chain_t          chain_i,
  input  wire [IDX_W-1:0]              zero_idx_i,
  input  wire [IDX_W-1:0]              arg_idx_i,
  output ksm_pkg::ksm_chain_t          chain_o,
  output logic [IDX_W-1:0]             zero_idx_o,
  output logic [IDX_W-1:0]             arg_idx_o
);
  import ksm_pkg::*;

  logic [HIST_W-1:0] code_r;
  logic [HIST_W-1:0] mask_r;
  logic [3:0]        args_r;
  logic              en_r;
  logic              zero_hit_r;
  logic              arg_hit_r;
  logic              hit;

  assign hit = en_r && ((history & mask_r) == code_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r       <= 1'b0;
      zero_hit_r <= 1'b0;
      arg_hit_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        en_r <= wr_entry.valid;
      end
      if (match_en) begin
        zero_hit_r <= hit && (args_r == 4'd0);
        arg_hit_r  <= hit && (args_r != 4'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_r <= wr_entry.code;
      mask_r <= wr_entry.mask;
      args_r <= wr_entry.args;
    end
  end

  // Lowest hit without arguments wins; highest hit with arguments wins.
  always_comb begin
    chain_o.zero_found = chain_i.zero_found | zero_hit_r;
    chain_o.arg_found  = chain_i.arg_found | arg_hit_r;
    chain_o.arg_cnt    = arg_hit_r ? args_r : chain_i.arg_cnt;
    zero_idx_o = (zero_hit_r && !chain_i.zero_found) ? IDX_W'(CELL_IDX) : zero_idx_i;
    arg_idx_o  = arg_hit_r ? IDX_W'(CELL_IDX) : arg_idx_i;
  end

endmodule

`default_nettype wire

// ===== src/key_sequence_matcher.sv =====
// Top level of the key sequence matcher: control, history, argument capture and cell row.
//
// Usage:
//   Input channel (in_valid/in_ready) carries either a key press (in_opcode = key) or a
//   pattern table write (in_opcode = write, slot in in_entry_index). Every transfer
//   yields exactly one result on the output channel (out_valid/out_ready).
//   A letter key in normal mode is shifted 5 bits into the history; in S_MATCH the cell
//   row compares it against all slots and registers the match bits, and in S_RESOLVE the
//   winners are resolved along the cell chain and loaded into the result register.
//   Writes, non-letter keys and keys taken as capture arguments skip the compare and
//   go from res_r to the result register in S_EMIT. The path lengths follow from the
//   registered match bits in each cell and the single output register.
//   One item is in flight at a time; in_ready is high while the control is idle,
//   including while a finished result still waits in the output register.
//   If the receiver stalls, the control holds its pending result until the output
//   register frees, and no new item is taken in the meantime.
//   Reset (rst_n low, synchronous) clears the history, capture state, slot enables
//   and the output valid; slot codes, masks and argument counts stay undefined until
//   written and are only read behind an enabled slot.
`timescale 1ns / 1ps
`default_nettype none

module key_sequence_matcher #(
  parameter int NUM_PATTERNS = 16,
  parameter int MAX_ARGS     = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_opcode,
  input  wire  [7:0]  in_key_code,
  input  wire  [3:0]  in_entry_index,
  input  wire  [31:0] in_entry_code,
  input  wire  [31:0] in_entry_mask,
  input  wire  [3:0]  in_entry_args,
  input  wire         in_entry_valid,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_consumed,
  output logic        out_fired,
  output logic [3:0]  out_fired_entry,
  output logic [3:0]  out_arg_count,
  output logic [63:0] out_arg_bytes
);
  import ksm_pkg::*;

  localparam int IDX_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int ARG_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

  // Control and capture state.
  ksm_state_t        state_r, state_nxt;
  logic [HIST_W-1:0] history_r, history_nxt;
  logic [IDX_W-1:0]  pending_r, pending_nxt;
  logic [3:0]        args_rem_r, args_rem_nxt;
  logic [3:0]        args_total_r, args_total_nxt;
  ksm_res_t          res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  ksm_res_t          out_res_r, out_res_nxt;

  // Argument buffer: one byte per position, written in key order.
  logic [7:0]        arg_buf_r [MAX_ARGS];
  logic              buf_we;
  logic [ARG_W-1:0]  buf_wa;

  logic              in_xfer;
  logic              out_free;
  logic [7:0]        key_lc;
  logic              is_letter;
  logic [3:0]        cap_pos;
  ksm_entry_t        wr_entry;
  logic [3:0]        wr_args;

  // Cell row wiring.
  ksm_chain_t        chain [NUM_PATTERNS+1];
  logic [IDX_W-1:0]  zero_idx [NUM_PATTERNS+1];
  logic [IDX_W-1:0]  arg_idx [NUM_PATTERNS+1];

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Lowercase only 'A'..'Z'; everything else passes through.
  assign key_lc = ((in_key_code >= UPPER_FIRST) && (in_key_code <= UPPER_LAST)) ?
                  (in_key_code + CASE_OFFSET) : in_key_code;
  assign is_letter = (key_lc >= LETTER_BASE) && (key_lc <= LETTER_LAST);

  assign cap_pos = args_total_r - args_rem_r;

  // Saturate the argument count of a slot write.
  assign wr_args = (in_entry_args > 4'(MAX_ARGS)) ? 4'(MAX_ARGS) : in_entry_args;
  assign wr_entry = '{code: in_entry_code, mask: in_entry_mask,
                      args: wr_args, valid: in_entry_valid};

  assign chain[0]    = '0;
  assign zero_idx[0] = '0;
  assign arg_idx[0]  = '0;

  for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_cell
    logic wr_sel;
    // Slots beyond the 4-bit index field are never selected.
    assign wr_sel = in_xfer && (in_opcode == OP_WRITE) && (32'(in_entry_index) == g);

    ksm_cell #(
      .IDX_W   (IDX_W),
      .CELL_IDX(g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_sel),
      .wr_entry  (wr_entry),
      .match_en  (state_r == S_MATCH),
      .history   (history_r),
      .chain_i   (chain[g]),
      .zero_idx_i(zero_idx[g]),
      .arg_idx_i (arg_idx[g]),
      .chain_o   (chain[g+1]),
      .zero_idx_o(zero_idx[g+1]),
      .arg_idx_o (arg_idx[g+1])
    );
  end

  // Next state, capture bookkeeping and result assembly.
  always_comb begin
    state_nxt      = state_r;
    history_nxt    = history_r;
    pending_nxt    = pending_r;
    args_rem_nxt   = args_rem_r;
    args_total_nxt = args_total_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_res_nxt    = out_res_r;
    buf_we         = 1'b0;
    buf_wa         = cap_pos[ARG_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt   = '0;
          state_nxt = S_EMIT;
          if (in_opcode == OP_KEY) begin
            if (args_rem_r != 4'd0) begin
              // Capture mode: store the key, fire on the last one.
              buf_we           = 1'b1;
              args_rem_nxt     = args_rem_r - 4'd1;
              res_nxt.consumed = 1'b1;
              if (args_rem_r == 4'd1) begin
                res_nxt.fired       = 1'b1;
                res_nxt.fired_entry = 4'(pending_r);
                res_nxt.arg_count   = args_total_r;
                for (int i = 0; i < MAX_ARGS; i++) begin
                  if (4'(i) < args_total_r) begin
                    res_nxt.arg_bytes[8*i +: 8] =
                      (4'(i) == cap_pos) ? key_lc : arg_buf_r[i];
                  end
                end
              end
            end else if (!is_letter) begin
              // Drop the history on anything outside the letter span.
              history_nxt = '0;
            end else begin
              history_nxt = {history_r[HIST_W-LETTER_BITS-1:0],
                             key_lc[LETTER_BITS-1:0] - LETTER_BASE[LETTER_BITS-1:0]};
              state_nxt   = S_MATCH;
            end
          end
        end
      end
      S_MATCH: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        // Hold the resolved match until the output register frees.
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_res_nxt           = '0;
          out_res_nxt.consumed  = chain[NUM_PATTERNS].zero_found |
                                  chain[NUM_PATTERNS].arg_found;
          out_res_nxt.fired     = chain[NUM_PATTERNS].zero_found;
          if (chain[NUM_PATTERNS].zero_found) begin
            out_res_nxt.fired_entry = 4'(zero_idx[NUM_PATTERNS]);
          end
          if (chain[NUM_PATTERNS].arg_found) begin
            // Arm the capture for the highest matching slot with arguments.
            pending_nxt    = arg_idx[NUM_PATTERNS];
            args_rem_nxt   = chain[NUM_PATTERNS].arg_cnt;
            args_total_nxt = chain[NUM_PATTERNS].arg_cnt;
          end
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      history_r    <= '0;
      pending_r    <= '0;
      args_rem_r   <= '0;
      args_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      history_r    <= history_nxt;
      pending_r    <= pending_nxt;
      args_rem_r   <= args_rem_nxt;
      args_total_r <= args_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
    if (buf_we) begin
      arg_buf_r[buf_wa] <= key_lc;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_consumed    = out_res_r.consumed;
  assign out_fired       = out_res_r.fired;
  assign out_fired_entry = out_res_r.fired_entry;
  assign out_arg_count   = out_res_r.arg_count;
  assign out_arg_bytes   = out_res_r.arg_bytes;

`ifndef SYNTHESIS
  // Remaining argument count never exceeds the armed total.
  a_rem_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    args_rem_r <= args_total_r)
    else $error("capture count above armed total");

  // A transfer always starts work that blocks the next one: in_ready drops in the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("second item taken while one is in flight");

  // Resolving an argument match arms the capture.
  a_capture_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE) && out_free && chain[NUM_PATTERNS].arg_found
      |=> (args_rem_r != 4'd0) && (args_rem_r == args_total_r))
    else $error("argument match did not arm capture");
`endif

endmodule

`default_nettype wire
